[design/nav_keyword_stream_parser_defines.svh]
// Assertion macros for the navigation keyword stream parser.
// Used by the top level only; expects clk and rst in scope.
`ifndef NAV_KEYWORD_STREAM_PARSER_DEFINES_SVH
`define NAV_KEYWORD_STREAM_PARSER_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define NKS_ASSERT_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define NKS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/nks_pkg.sv]
// Shared types, keyword table and byte classification for the keyword parser.
// No dependencies.
`default_nettype none

package nks_pkg;

  localparam int RING_DEPTH_DEF = 256;
  localparam int WORD_MAX_DEF   = 31;

  localparam int KW_COUNT   = 47;
  localparam int KW_MAX_LEN = 11;
  localparam int KW_TEXT_W  = KW_MAX_LEN * 8;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_NEXT     = 3'd1,
    ACT_PREV     = 3'd2,
    ACT_ACTIVATE = 3'd3,
    ACT_BACK     = 3'd4,
    ACT_TAB      = 3'd5,
    ACT_BACKTAB  = 3'd6
  } action_t;

  typedef struct packed {
    logic [3:0]           len;
    action_t              act;
    logic [KW_TEXT_W-1:0] text;   // right-aligned, zero padded on the left
  } kw_t;

  // Controls from the byte classifier to the word matcher
  typedef struct packed {
    logic       add_char;
    logic       end_word;
    logic [6:0] ch;
  } nks_word_ctl_t;

  // Status of the word under collection
  typedef struct packed {
    logic    open;
    action_t act;
  } nks_word_status_t;

  function automatic kw_t kw_make(action_t act, logic [KW_TEXT_W-1:0] text);
    kw_t e;
    e.len  = '0;
    e.act  = act;
    e.text = text;
    for (int i = 0; i < KW_MAX_LEN; i++) begin
      if (text[i*8 +: 8] != 8'h00) e.len = e.len + 4'd1;
    end
    return e;
  endfunction

  function automatic kw_t kw_entry(int k);
    kw_t e;
    e = kw_make(ACT_NONE, '0);
    case (k)
      0:  e = kw_make(ACT_NEXT, "next");
      1:  e = kw_make(ACT_NEXT, "cw");
      2:  e = kw_make(ACT_NEXT, "right");
      3:  e = kw_make(ACT_NEXT, "down");
      4:  e = kw_make(ACT_NEXT, "fwd");
      5:  e = kw_make(ACT_NEXT, "forward");
      6:  e = kw_make(ACT_NEXT, "inc");
      7:  e = kw_make(ACT_NEXT, "r");
      8:  e = kw_make(ACT_PREV, "prev");
      9:  e = kw_make(ACT_PREV, "ccw");
      10: e = kw_make(ACT_PREV, "left");
      11: e = kw_make(ACT_PREV, "up");
      12: e = kw_make(ACT_PREV, "rev");
      13: e = kw_make(ACT_PREV, "reverse");
      14: e = kw_make(ACT_PREV, "dec");
      15: e = kw_make(ACT_PREV, "l");
      16: e = kw_make(ACT_ACTIVATE, "activate");
      17: e = kw_make(ACT_ACTIVATE, "select");
      18: e = kw_make(ACT_ACTIVATE, "sel");
      19: e = kw_make(ACT_ACTIVATE, "ok");
      20: e = kw_make(ACT_ACTIVATE, "enter");
      21: e = kw_make(ACT_ACTIVATE, "push");
      22: e = kw_make(ACT_ACTIVATE, "press");
      23: e = kw_make(ACT_ACTIVATE, "click");
      24: e = kw_make(ACT_ACTIVATE, "fire");
      25: e = kw_make(ACT_ACTIVATE, "s");
      26: e = kw_make(ACT_ACTIVATE, "p");
      27: e = kw_make(ACT_BACK, "back");
      28: e = kw_make(ACT_BACK, "esc");
      29: e = kw_make(ACT_BACK, "escape");
      30: e = kw_make(ACT_BACK, "cancel");
      31: e = kw_make(ACT_BACK, "long");
      32: e = kw_make(ACT_BACK, "longpress");
      33: e = kw_make(ACT_BACK, "home");
      34: e = kw_make(ACT_BACK, "exit");
      35: e = kw_make(ACT_BACK, "b");
      36: e = kw_make(ACT_TAB, "tab");
      37: e = kw_make(ACT_TAB, "screen");
      38: e = kw_make(ACT_TAB, "screen\137next");
      39: e = kw_make(ACT_TAB, "page");
      40: e = kw_make(ACT_TAB, "page\137next");
      41: e = kw_make(ACT_TAB, "t");
      42: e = kw_make(ACT_BACKTAB, "tab\137prev");
      43: e = kw_make(ACT_BACKTAB, "screen\137prev");
      44: e = kw_make(ACT_BACKTAB, "page\137prev");
      45: e = kw_make(ACT_BACKTAB, "shift\137tab");
      46: e = kw_make(ACT_BACKTAB, "y");
      default: e = kw_make(ACT_NONE, '0);
    endcase
    return e;
  endfunction

  // Left-align keyword text so that character j sits at a fixed slot
  function automatic logic [KW_TEXT_W-1:0] kw_left(kw_t e);
    return e.text << ((KW_MAX_LEN - int'(e.len)) * 8);
  endfunction

  function automatic logic [6:0] to_lower(logic [6:0] c);
    if (c >= 7'h41 && c <= 7'h5A) return c + 7'h20;
    return c;
  endfunction

  function automatic action_t symbol_action(logic [7:0] b);
    action_t a;
    unique case (b)
      "+", ">": a = ACT_NEXT;
      "-", "<": a = ACT_PREV;
      "*", "!": a = ACT_ACTIVATE;
      "~", "^": a = ACT_BACK;
      default:  a = ACT_NONE;
    endcase
    return a;
  endfunction

  function automatic logic is_delimiter(logic [7:0] b);
    return (b == " ") || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A) ||
           (b == ",") || (b == ";");
  endfunction

  function automatic logic is_printable(logic [7:0] b);
    return (b >= 8'h21) && (b <= 8'h7E);
  endfunction

endpackage

`default_nettype wire

[design/nav_keyword_stream_parser.sv]
// Top level of the navigation keyword stream parser: byte classifier, action
// ring in RAM and result path. Depends on nks_pkg, nks_ram, nks_word_matcher,
// nks_out_queue and nav_keyword_stream_parser_defines.svh.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------
//   in      | in_valid / in_ready  | command[0], data_byte[7:0]
//   out     | out_valid / out_ready| action[2:0]
//
// A symbol byte that closes a word with a recognized action makes two ring
// writes, the word's action and then its own from a deferred slot while input
// is held, since the ring RAM has one write port. A take's result enters the
// result queue in the cycle after its transfer (RAM read) and transfers on out
// from there. in_ready drops while queued results plus a read in flight reach
// two, so takes back to back with out_ready high cannot all be taken
// without a pause. Reset clears the pointers and the word state at once; the
// ring RAM needs no clearing pass.
`default_nettype none
`include "nav_keyword_stream_parser_defines.svh"

module nav_keyword_stream_parser import nks_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int WORD_MAX   = WORD_MAX_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       command,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      action
);

  localparam int PTR_W = $clog2(RING_DEPTH);

  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [PTR_W-1:0] wp_adv;
  logic [PTR_W-1:0] rp_adv;
  logic             pend;
  action_t          pend_act;
  logic             rd_valid;
  logic             rd_hit;

  logic             accept;
  logic             take;
  logic             byte_in;
  action_t          sym;
  logic             delim;
  logic             closes;
  logic             word_push;
  logic             push_req;
  action_t          push_act;
  logic             ring_full;
  logic             ram_we;
  logic [2:0]       ram_rdata;
  logic             ring_empty;
  logic [1:0]       q_level;
  logic [2:0]       occupancy;
  action_t          res_act;
  action_t          out_act;

  nks_word_ctl_t    wctl;
  nks_word_status_t wstat;

  function automatic logic [PTR_W-1:0] ring_advance(logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign wp_adv     = ring_advance(wp);
  assign rp_adv     = ring_advance(rp);
  assign ring_full  = (wp_adv == rp);
  assign ring_empty = (rp == wp);

  // Hold input while a deferred symbol is written or queued results plus a read in flight reach two
  assign occupancy = {1'b0, q_level} + {2'b00, rd_valid};
  assign in_ready  = !pend && (occupancy < 3'd2);
  assign accept    = in_valid && in_ready;
  assign take      = accept && command;
  assign byte_in   = accept && !command;

  // Classify the byte
  assign sym    = symbol_action(data_byte);
  assign delim  = is_delimiter(data_byte);
  assign closes = byte_in && ((sym != ACT_NONE) || delim);

  assign wctl.end_word = closes;
  assign wctl.add_char = byte_in && is_printable(data_byte) && (sym == ACT_NONE);
  assign wctl.ch       = data_byte[6:0];

  assign word_push = closes && wstat.open && (wstat.act != ACT_NONE);

  // Select the ring write: deferred symbol, word action, then symbol
  always_comb begin
    priority if (pend) begin
      push_req = 1'b1;
      push_act = pend_act;
    end else if (word_push) begin
      push_req = 1'b1;
      push_act = wstat.act;
    end else if (byte_in && (sym != ACT_NONE)) begin
      push_req = 1'b1;
      push_act = sym;
    end else begin
      push_req = 1'b0;
      push_act = ACT_NONE;
    end
  end

  // Drop the newest action when the ring is full
  assign ram_we = push_req && !ring_full;

  // Pointers, deferred symbol and read tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      rp       <= '0;
      pend     <= 1'b0;
      rd_valid <= 1'b0;
      rd_hit   <= 1'b0;
    end else begin
      if (ram_we) wp <= wp_adv;
      if (take && !ring_empty) rp <= rp_adv;
      pend     <= word_push && (sym != ACT_NONE);
      rd_valid <= take;
      rd_hit   <= take && !ring_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (word_push) pend_act <= sym;
  end

  nks_ram #(
    .WIDTH (3),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (push_act),
    .raddr (rp),
    .rdata (ram_rdata)
  );

  nks_word_matcher #(
    .WORD_MAX (WORD_MAX)
  ) u_match (
    .clk    (clk),
    .rst    (rst),
    .ctl    (wctl),
    .status (wstat)
  );

  assign res_act = rd_hit ? action_t'(ram_rdata) : ACT_NONE;

  nks_out_queue u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (rd_valid),
    .push_act  (res_act),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_act   (out_act),
    .level     (q_level)
  );

  assign action = out_act;

  // Checks
  `NKS_ASSERT_HOLDS(a_occupancy, occupancy <= 3'd2, "result storage overrun")
  `NKS_ASSERT_NEXT(a_push_nonempty, ram_we, wp != rp, "ring empty after a write")
  `NKS_ASSERT_NEXT(a_take_reads, take, rd_valid, "take transfer without ring read")
  `NKS_ASSERT_NEXT(a_pend_blocks, word_push && (sym != ACT_NONE), !in_ready,
                   "input taken during deferred symbol write")

endmodule

`default_nettype wire

[design/nks_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module nks_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/nks_word_matcher.sv]
// Incremental keyword matcher: narrows a candidate set per received character.
// Depends on nks_pkg.
`default_nettype none

module nks_word_matcher import nks_pkg::*; #(
  parameter int WORD_MAX = WORD_MAX_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire nks_word_ctl_t    ctl,
  output nks_word_status_t      status
);

  localparam int LEN_W = $clog2(WORD_MAX + 1);

  logic [LEN_W-1:0]    word_length;
  logic [KW_COUNT-1:0] cand;
  logic [KW_COUNT-1:0] hit;
  logic [KW_COUNT-1:0] full_hit;
  logic [6:0]          lc;
  action_t             kw_act [KW_COUNT];

  assign lc = to_lower(ctl.ch);

  // Per keyword: compare the expected character at the current position
  for (genvar k = 0; k < KW_COUNT; k++) begin : g_kw
    localparam kw_t                  E = kw_entry(k);
    localparam logic [KW_TEXT_W-1:0] L = kw_left(E);
    logic [6:0] expect_ch;

    always_comb begin
      expect_ch = '0;
      for (int j = 0; j < KW_MAX_LEN; j++) begin
        if (word_length == LEN_W'(j)) expect_ch = L[(KW_MAX_LEN-1-j)*8 +: 7];
      end
      hit[k]      = (word_length < LEN_W'(E.len)) && (expect_ch == lc);
      full_hit[k] = cand[k] && (word_length == LEN_W'(E.len));
    end

    assign kw_act[k] = E.act;
  end

  // Pick the first keyword in table order that matches in full
  always_comb begin
    status.act = ACT_NONE;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (full_hit[k]) status.act = kw_act[k];
    end
    status.open = (word_length != '0);
  end

  // Advance the word: restart on end, narrow candidates on a kept character
  always_ff @(posedge clk) begin
    if (rst) begin
      word_length <= '0;
      cand        <= '1;
    end else if (ctl.end_word) begin
      word_length <= '0;
      cand        <= '1;
    end else if (ctl.add_char && (word_length < LEN_W'(WORD_MAX))) begin
      word_length <= word_length + LEN_W'(1);
      cand        <= cand & hit;
    end
  end

endmodule

`default_nettype wire

[design/nks_out_queue.sv]
// Two-entry result queue: output register plus skid slot.
// Depends on nks_pkg.
`default_nettype none

module nks_out_queue import nks_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire action_t push_act,
  output logic         out_valid,
  input  wire logic    out_ready,
  output action_t      out_act,
  output logic [1:0]   level
);

  logic [1:0] cnt;
  action_t    slot0;
  action_t    slot1;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt != 2'd0);
  assign out_act   = slot0;
  assign level     = cnt;

  // Occupancy count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (push && !pop) begin
      cnt <= cnt + 2'd1;
    end else if (pop && !push) begin
      cnt <= cnt - 2'd1;
    end
  end

  // Slot data: shift on pop, fill the first free slot on push
  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (cnt == 2'd0) slot0 <= push_act;
        else             slot1 <= push_act;
      end
      2'b01: slot0 <= slot1;
      2'b11: begin
        if (cnt == 2'd1) begin
          slot0 <= push_act;
        end else begin
          slot0 <= slot1;
          slot1 <= push_act;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
